/* rtl/mie_pkg.sv */
// ----------------------------------------------------------------------------
// mie_pkg
// Shared constants and types for the extended Euclidean modular inverse block.
// ----------------------------------------------------------------------------
`default_nettype none

package mie_pkg;

    // Default operand width of the gcd operands
    localparam int OPERAND_WIDTH_DEF = 32;

    // Sequencer states of the top level
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

/* rtl/mie_divmac.sv */
// ----------------------------------------------------------------------------
// mie_divmac
// Bit-serial restoring divider that also forms quotient * coefficient for two
// coefficients, one quotient bit per cycle, MSB first (Horner accumulation).
// ----------------------------------------------------------------------------
`default_nettype none

module mie_divmac
    import mie_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [OPERAND_WIDTH-1:0] i_dividend,
    input  wire logic [OPERAND_WIDTH-1:0] i_divisor,
    input  wire logic [OPERAND_WIDTH:0]   i_coef_x,
    input  wire logic [OPERAND_WIDTH:0]   i_coef_y,
    output logic                          o_done,
    output logic [OPERAND_WIDTH-1:0]      o_rem,
    output logic [OPERAND_WIDTH:0]        o_prod_x,
    output logic [OPERAND_WIDTH:0]        o_prod_y
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_dvd;
    logic [W-1:0]  r_rem;
    logic [W:0]    r_px;
    logic [W:0]    r_py;

    logic [W:0]    shifted;
    logic [W+1:0]  diff;
    logic          qbit;
    logic [W-1:0]  n_rem;
    logic [W:0]    n_px;
    logic [W:0]    n_py;

    // One restoring step: shift in the next dividend bit, trial subtract
    always_comb begin
        shifted = {r_rem, r_dvd[W-1]};
        diff    = {1'b0, shifted} - {2'b00, i_divisor};
        qbit    = ~diff[W+1];
        n_rem   = qbit ? diff[W-1:0] : shifted[W-1:0];
        n_px    = {r_px[W-1:0], 1'b0} + (qbit ? i_coef_x : '0);
        n_py    = {r_py[W-1:0], 1'b0} + (qbit ? i_coef_y : '0);
    end

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and the two product accumulators
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_px  <= '0;
            r_py  <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[W-2:0], 1'b0};
            r_rem <= n_rem;
            r_px  <= n_px;
            r_py  <= n_py;
        end
    end

    assign o_done   = r_done;
    assign o_rem    = r_rem;
    assign o_prod_x = r_px;
    assign o_prod_y = r_py;

endmodule

`default_nettype wire

/* rtl/modular_inverse_ext_euclid_top.sv */
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_top
// Extended Euclidean gcd, Bezout coefficients and modular inverse.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel takes one beat with value_in and modulus. Master channel
//   returns one beat per input with gcd_out, coef_value, coef_modulus and
//   inverse_out in tdata, inverse_ok in tuser. Coefficients are signed
//   two's complement, OPERAND_WIDTH+1 bits, not reduced modulo the modulus.
//   A zero modulus returns gcd = value_in, coef_value = 1, coef_modulus = 0.
// Throughput:
//   Each Euclid step runs through the bit-serial divide/multiply-accumulate
//   unit, which produces one quotient bit per cycle. One beat takes k
//   quotient steps, with k up to about 46 at 32 bits.
//   o_s_axis_tready is high only while the sequencer is idle.
// Reset:
//   Synchronous active-low reset returns the sequencer to idle and drops
//   o_m_axis_tvalid.
// Stall:
//   The result sits in an output register; the next input beat is taken while
//   it waits. A finished second result waits until the first one leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_inverse_ext_euclid_top
    import mie_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // tdata: value_in, modulus (low to high), zero padded
    input  wire logic [((2*OPERAND_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // tdata: gcd_out, coef_value, coef_modulus, inverse_out (low to high)
    output logic [((4*OPERAND_WIDTH+3+7)/8)*8-1:0] o_m_axis_tdata,
    // tuser: inverse_ok
    output logic                       o_m_axis_tuser
);

    localparam int W      = OPERAND_WIDTH;
    localparam int OUT_TW = ((4*W+3+7)/8)*8;
    localparam int OUT_PW = 4*W + 3;

    t_state        r_state;
    t_state        n_state;

    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;
    logic [W:0]    r_xp;
    logic [W:0]    r_xc;
    logic [W:0]    r_yp;
    logic [W:0]    r_yc;

    logic          r_out_valid;
    logic [OUT_PW-1:0] r_out_data;
    logic          r_out_ok;

    logic          in_beat;
    logic          div_start;
    logic          out_load;
    logic          div_done;
    logic [W-1:0]  div_rem;
    logic [W:0]    div_px;
    logic [W:0]    div_py;
    logic          res_ok;

    // Shared divide / multiply-accumulate unit
    mie_divmac #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_divmac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .i_coef_x   (r_xc),
        .i_coef_y   (r_yc),
        .o_done     (div_done),
        .o_rem      (div_rem),
        .o_prod_x   (div_px),
        .o_prod_y   (div_py)
    );

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and control strobes
    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        div_start       = 1'b0;
        out_load        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_b == '0) begin
                    n_state = S_FINISH;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_CHECK;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign in_beat = o_s_axis_tready & i_s_axis_tvalid;

    // Euclid working registers: load on input beat, advance one step on done
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_a  <= i_s_axis_tdata[W-1:0];
            r_b  <= i_s_axis_tdata[2*W-1:W];
            r_xp <= (W+1)'(1);
            r_xc <= '0;
            r_yp <= '0;
            r_yc <= (W+1)'(1);
        end else if (r_state == S_DIV && div_done) begin
            r_a  <= r_b;
            r_b  <= div_rem;
            r_xp <= r_xc;
            r_xc <= r_xp - div_px;
            r_yp <= r_yc;
            r_yc <= r_yp - div_py;
        end
    end

    assign res_ok = (r_a == W'(1));

    // Output register: hold until the master side takes the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {(res_ok ? r_xp : {(W+1){1'b0}}), r_yp, r_xp, r_a};
            r_out_ok   <= res_ok;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TW'(r_out_data);
    assign o_m_axis_tuser  = r_out_ok;

endmodule

`default_nettype wire

/* rtl/mie_checker.sv */
// ----------------------------------------------------------------------------
// mie_checker
// Port-level checks for the modular inverse block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mie_checker
    import mie_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    input  wire logic                  o_s_axis_tready,
    input  wire logic                  o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    input  wire logic [((4*OPERAND_WIDTH+3+7)/8)*8-1:0] o_m_axis_tdata,
    input  wire logic                  o_m_axis_tuser
);

    localparam int W = OPERAND_WIDTH;

    logic [W-1:0] chk_gcd;
    logic [W:0]   chk_inv;
    logic [W:0]   chk_cv;

    assign chk_gcd = o_m_axis_tdata[W-1:0];
    assign chk_cv  = o_m_axis_tdata[2*W:W];
    assign chk_inv = o_m_axis_tdata[4*W+2:3*W+2];

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result beat changed");

    // Block is busy in the cycle after taking an input beat
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken again right after a beat");

    // Inverse flag matches gcd of one, and inverse equals coefficient
    a_ok_gcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == (chk_gcd == W'(1))))
        else $error("inverse flag disagrees with gcd");

    a_inv_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tuser ? (chk_inv == chk_cv) : (chk_inv == '0)))
        else $error("inverse field inconsistent with flag");

    // Reset drops the result valid
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind modular_inverse_ext_euclid_top mie_checker #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
) u_mie_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

/* tb/tb_modular_inverse_ext_euclid_top.sv */
// ----------------------------------------------------------------------------
// tb_modular_inverse_ext_euclid_top
// Self-checking bench for the extended Euclidean modular inverse block.
// A queue of operand pairs feeds a clocked stream driver. Each accepted beat
// is run through a local extended Euclid model, and the expected gcd,
// coefficients, inverse and ok flag are queued. A clocked monitor compares
// every result beat with the oldest expectation. Stimulus starts with
// directed corner pairs, then random pairs of several shapes, in three
// phases of sender and receiver throttling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_modular_inverse_ext_euclid_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mie_pkg::*;

    localparam int W            = OPERAND_WIDTH_DEF;
    localparam int IW           = ((2*W+7)/8)*8;
    localparam int OW           = ((4*W+3+7)/8)*8;
    localparam int RANDOM_ITEMS = 350;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int TAIL_CYCLES  = 2000;
    localparam int LONG_HOLD    = 4000;
    localparam int HOLD_AT      = 60;

    // Throttling phases of the run
    typedef enum logic [1:0] {
        PH_RECV_SLOW,
        PH_SEND_SLOW,
        PH_FULL_RATE
    } t_phase;

    typedef struct {
        logic [W-1:0] value;
        logic [W-1:0] modulus;
        t_phase       phase;
        bit           drain_before;
    } t_operands;

    typedef struct {
        logic [W-1:0] gcd;
        logic [W:0]   coef_v;
        logic [W:0]   coef_m;
        logic         ok;
        logic [W:0]   inv;
    } t_bezout;

    logic          clk;
    logic          rst_n    = 1'b0;
    logic          s_valid  = 1'b0;
    logic [IW-1:0] s_tdata  = '0;
    logic          m_ready  = 1'b0;
    wire logic          s_ready;
    wire logic          m_valid;
    wire logic [OW-1:0] m_tdata;
    wire logic          m_tuser;

    t_operands operand_q[$];
    t_bezout   bezout_q[$];
    t_operands s_cur;
    t_phase    feed_phase = PH_RECV_SLOW;
    int        sent_cnt   = 0;
    int        recv_cnt   = 0;
    int        err_count  = 0;
    int        cycle_cnt  = 0;
    int        hold_left  = 0;
    bit        hold_done  = 1'b0;

    modular_inverse_ext_euclid_top DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),   // value_in, modulus (low to high)
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),   // gcd, coef_value, coef_modulus, inverse_out
        .o_m_axis_tuser  (m_tuser)    // inverse_ok
    );

    // Quotient-based extended Euclid, wrapping at 64 bits
    function automatic t_bezout solve_bezout(logic [W-1:0] v, logic [W-1:0] m);
        logic [63:0] a, b, xp, xc, yp, yc, q, r, nx, ny;
        t_bezout     res;
        a  = 64'(v);
        b  = 64'(m);
        xp = 64'd1;
        xc = 64'd0;
        yp = 64'd0;
        yc = 64'd1;
        while (b != 64'd0) begin
            q  = a / b;
            r  = a - q * b;
            nx = xp - q * xc;
            ny = yp - q * yc;
            a  = b;
            b  = r;
            xp = xc;
            xc = nx;
            yp = yc;
            yc = ny;
        end
        res.gcd    = a[W-1:0];
        res.coef_v = xp[W:0];
        res.coef_m = yp[W:0];
        res.ok     = (a == 64'd1);
        res.inv    = res.ok ? xp[W:0] : '0;
        return res;
    endfunction

    function automatic void queue_operands(logic [W-1:0] v, logic [W-1:0] m,
                                           t_phase p, bit drain);
        t_operands op;
        op.value        = v;
        op.modulus      = m;
        op.phase        = p;
        op.drain_before = drain;
        operand_q.push_back(op);
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endfunction

    // Clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog on total cycles
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb_modular_inverse_ext_euclid_top failed");
        $finish;
    end

    // Build stimulus, release reset, wait for the last result
    initial begin
        logic [63:0]  fib [48];
        logic [W-1:0] v, m, tmp, g;
        t_phase       p;
        int           k, wv, wm;
        bit           drain;

        fib[0] = 64'd0;
        fib[1] = 64'd1;
        for (k = 2; k < 48; k++) fib[k] = fib[k-1] + fib[k-2];

        // Directed corners
        queue_operands('0, '0, PH_RECV_SLOW, 1'b0);
        queue_operands('0, 32'd5, PH_RECV_SLOW, 1'b0);
        queue_operands(32'd7, '0, PH_RECV_SLOW, 1'b0);
        queue_operands(32'd1, '0, PH_RECV_SLOW, 1'b0);
        queue_operands(32'd3, 32'd7, PH_RECV_SLOW, 1'b0);
        queue_operands(32'd7, 32'd3, PH_RECV_SLOW, 1'b0);
        queue_operands(32'd6, 32'd9, PH_RECV_SLOW, 1'b0);
        queue_operands(32'd1, 32'd1, PH_RECV_SLOW, 1'b0);
        queue_operands('1, '1, PH_RECV_SLOW, 1'b0);
        queue_operands('1, '0, PH_RECV_SLOW, 1'b0);
        queue_operands('0, '1, PH_RECV_SLOW, 1'b0);
        queue_operands('1, 32'hFFFF_FFFE, PH_RECV_SLOW, 1'b0);
        queue_operands(32'hFFFF_FFFE, '1, PH_RECV_SLOW, 1'b0);
        // Consecutive Fibonacci numbers take the most quotient steps
        queue_operands(fib[47][W-1:0], fib[46][W-1:0], PH_RECV_SLOW, 1'b0);
        queue_operands(fib[46][W-1:0], fib[47][W-1:0], PH_RECV_SLOW, 1'b0);
        queue_operands(32'h8000_0000, '1, PH_RECV_SLOW, 1'b0);
        queue_operands(32'd1, '1, PH_RECV_SLOW, 1'b0);
        queue_operands(32'd2, '1, PH_RECV_SLOW, 1'b0);
        queue_operands(32'h1234_5678, 32'h8000_0000, PH_RECV_SLOW, 1'b0);
        queue_operands(32'd3, 32'h8000_0000, PH_RECV_SLOW, 1'b0);
        queue_operands(32'd17, 32'd3120, PH_RECV_SLOW, 1'b0);
        queue_operands(32'd5, 32'd5, PH_RECV_SLOW, 1'b0);
        queue_operands(32'd1, 32'd2, PH_RECV_SLOW, 1'b0);
        queue_operands(32'h8000_0000, 32'h8000_0000, PH_RECV_SLOW, 1'b0);

        // Random pairs of several shapes
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            p = (i < 160) ? PH_RECV_SLOW : (i < 255) ? PH_SEND_SLOW : PH_FULL_RATE;
            drain = (i == 0) || (i == 100) || (i == 160) || (i == 255);
            v = $urandom;
            m = $urandom;
            case ($urandom_range(9))
                4: begin
                    // short operands
                    wv = $urandom_range(1, W);
                    wm = $urandom_range(1, W);
                    v  = v & W'((64'd1 << wv) - 64'd1);
                    m  = m & W'((64'd1 << wm) - 64'd1);
                end
                5: m = W'(64'd1 << $urandom_range(0, W-1));
                6: begin
                    k = $urandom_range(1, 46);
                    v = fib[k+1][W-1:0];
                    m = fib[k][W-1:0];
                    if ($urandom_range(1) == 1) begin
                        tmp = v;
                        v   = m;
                        m   = tmp;
                    end
                end
                7: begin
                    if ($urandom_range(1) == 1) v = '0;
                    else m = '0;
                end
                8: begin
                    // shared factor, no inverse
                    g = W'($urandom_range(2, 1000));
                    v = g * W'($urandom_range(0, 4000000));
                    m = g * W'($urandom_range(1, 4000000));
                end
                9: begin
                    v = ~W'($urandom_range(0, 15));
                    m = ($urandom_range(3) == 0) ? v : ~W'($urandom_range(0, 15));
                end
                default: ;
            endcase
            queue_operands(v, m, p, drain);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (operand_q.size() != 0 || s_valid || recv_cnt != sent_cnt) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (err_count == 0 && recv_cnt == sent_cnt) begin
            $display("tb_modular_inverse_ext_euclid_top passed");
        end else begin
            $display("tb_modular_inverse_ext_euclid_top failed");
        end
        $finish;
    end

    // Drive operand beats; predict on each accepted beat
    always @(posedge clk) begin
        t_operands nxt;
        int        idle;
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                bezout_q.push_back(solve_bezout(s_cur.value, s_cur.modulus));
                sent_cnt <= sent_cnt + 1;
            end
            if (!s_valid || s_ready) begin
                if (operand_q.size() == 0) begin
                    s_valid <= 1'b0;
                end else begin
                    idle = (operand_q[0].phase == PH_RECV_SLOW) ? 32 :
                           (operand_q[0].phase == PH_SEND_SLOW) ? 73 : 0;
                    // hold off until every outstanding result is back
                    if (operand_q[0].drain_before && (s_valid || recv_cnt != sent_cnt)) begin
                        s_valid <= 1'b0;
                    end else if ($urandom_range(99) < idle) begin
                        s_valid <= 1'b0;
                    end else begin
                        nxt        = operand_q.pop_front();
                        s_cur      = nxt;
                        s_tdata    <= IW'({nxt.modulus, nxt.value});
                        s_valid    <= 1'b1;
                        feed_phase <= nxt.phase;
                    end
                end
            end
        end
    end

    // Accept result beats and compare with the oldest expectation
    always @(posedge clk) begin
        t_bezout want;
        int      idle;
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (recv_cnt >= sent_cnt) begin
                    err_count++;
                    $display("%0t ns: result beat with nothing expected, got %h", $time,
                             m_tdata);
                end else begin
                    want = bezout_q.pop_front();
                    check_field("gcd_out", 64'(want.gcd), 64'(m_tdata[W-1:0]));
                    check_field("coef_value", 64'(want.coef_v), 64'(m_tdata[2*W:W]));
                    check_field("coef_modulus", 64'(want.coef_m), 64'(m_tdata[3*W+1:2*W+1]));
                    check_field("inverse_out", 64'(want.inv), 64'(m_tdata[4*W+2:3*W+2]));
                    check_field("inverse_ok", 64'(want.ok), 64'(m_tuser));
                    recv_cnt <= recv_cnt + 1;
                end
            end
            // one long back-pressure stretch so the input side stalls
            if (!hold_done && recv_cnt == HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            idle = (feed_phase == PH_RECV_SLOW) ? 73 : (feed_phase == PH_SEND_SLOW) ? 32 : 0;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= idle);
            end
        end
    end

endmodule

`default_nettype wire

/* files.f */
rtl/mie_pkg.sv
rtl/mie_divmac.sv
rtl/modular_inverse_ext_euclid_top.sv
rtl/mie_checker.sv
tb/tb_modular_inverse_ext_euclid_top.sv
